### rtl/uart_register_model_defines.svh
// Assertion macros shared by the RTL files of the UART register model.
// Every assertion samples on clk_i and is disabled while rst_ni is low.
`ifndef UART_REGISTER_MODEL_DEFINES_SVH
`define UART_REGISTER_MODEL_DEFINES_SVH

`ifndef ASSERT_OFF
`define URM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define URM_ASSERT_IF(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("%m: assertion failed");
`else
`define URM_ASSERT(lbl, prop)
`define URM_ASSERT_IF(lbl, cond, prop)
`endif

`endif

### rtl/urm_pkg.sv
`default_nettype none

package urm_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned DataW = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AddrW-1:0] UartRbrOff = AddrW'(0);
  localparam logic [AddrW-1:0] UartIerOff = AddrW'(1);
  localparam logic [AddrW-1:0] UartFcrOff = AddrW'(2);
  localparam logic [AddrW-1:0] UartLcrOff = AddrW'(3);
  localparam logic [AddrW-1:0] UartLsrOff = AddrW'(5);
  localparam logic [AddrW-1:0] UartScrOff = AddrW'(7);
  localparam logic [AddrW-1:0] MtimeOff = AddrW'(49144);

  localparam int unsigned DlabBit = 7;
  localparam logic [ByteW-1:0] LsrThre = 8'h20;
  localparam logic [ByteW-1:0] LsrDr = 8'h01;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindRx    = 2'd2,
    KindTick  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUartBase  = 2'd0,
    CfgClintBase = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0] uart_base;
    logic [AddrW-1:0] clint_base;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_value;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             bus_error;
    logic             tx_valid;
    logic [ByteW-1:0] tx_data;
    logic             rx_taken;
  } result_t;

endpackage

`default_nettype wire

### rtl/urm_cfg.sv
`default_nettype none

module urm_cfg
  import urm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  output cfg_t                    cfg_o
);

  logic [AddrW-1:0] uart_base_q, uart_base_d;
  logic [AddrW-1:0] clint_base_q, clint_base_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    uart_base_d  = uart_base_q;
    clint_base_d = clint_base_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgUartBase:  uart_base_d = cfg_data_i;
        CfgClintBase: clint_base_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uart_base_q  <= '0;
      clint_base_q <= '0;
    end else begin
      uart_base_q  <= uart_base_d;
      clint_base_q <= clint_base_d;
    end
  end

  assign cfg_o.uart_base  = uart_base_q;
  assign cfg_o.clint_base = clint_base_q;

endmodule

`default_nettype wire

### rtl/urm_exec.sv
`default_nettype none

`include "uart_register_model_defines.svh"

module urm_exec
  import urm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  output result_t    result_o
);

  logic [ByteW-1:0] lcr_q, lcr_d;
  logic [ByteW-1:0] ier_q, ier_d;
  logic [ByteW-1:0] scr_q, scr_d;
  logic [ByteW-1:0] dll_q, dll_d;
  logic [ByteW-1:0] dlm_q, dlm_d;
  logic             rx_valid_q, rx_valid_d;
  logic [ByteW-1:0] rx_byte_q, rx_byte_d;
  logic [DataW-1:0] time_q, time_d;

  logic [AddrW-1:0] uart_off;
  logic [AddrW-1:0] clint_off;
  logic             hit_rbr, hit_ier, hit_fcr, hit_lcr, hit_lsr, hit_scr, hit_mtime;
  logic             dlab;
  logic [ByteW-1:0] wr_byte;

  assign uart_off  = item_i.address - cfg_i.uart_base;
  assign clint_off = item_i.address - cfg_i.clint_base;
  assign hit_rbr   = (uart_off == UartRbrOff);
  assign hit_ier   = (uart_off == UartIerOff);
  assign hit_fcr   = (uart_off == UartFcrOff);
  assign hit_lcr   = (uart_off == UartLcrOff);
  assign hit_lsr   = (uart_off == UartLsrOff);
  assign hit_scr   = (uart_off == UartScrOff);
  assign hit_mtime = (clint_off == MtimeOff);
  assign dlab      = lcr_q[DlabBit];
  assign wr_byte   = item_i.write_value[ByteW-1:0];

  always_comb begin
    result_o   = '0;
    lcr_d      = lcr_q;
    ier_d      = ier_q;
    scr_d      = scr_q;
    dll_d      = dll_q;
    dlm_d      = dlm_q;
    rx_valid_d = rx_valid_q;
    rx_byte_d  = rx_byte_q;
    time_d     = time_q;
    unique case (item_i.kind)
      KindRead: begin
        // The UART offsets are distinct; only mtime can overlap them.
        priority if (hit_lcr) begin
          result_o.read_data = DataW'(lcr_q);
        end else if (hit_ier) begin
          result_o.read_data = DataW'(ier_q);
        end else if (hit_lsr) begin
          result_o.read_data = DataW'(LsrThre | (rx_valid_q ? LsrDr : '0));
        end else if (hit_scr) begin
          result_o.read_data = DataW'(scr_q);
        end else if (hit_mtime) begin
          result_o.read_data = time_q;
        end else if (hit_rbr) begin
          if (rx_valid_q) begin
            result_o.read_data = DataW'(rx_byte_q);
            rx_valid_d         = 1'b0;
          end
        end else begin
          result_o.bus_error = 1'b1;
        end
      end
      KindWrite: begin
        priority if (hit_rbr) begin
          if (dlab) begin
            dll_d = wr_byte;
          end else begin
            result_o.tx_valid = 1'b1;
            result_o.tx_data  = wr_byte;
          end
        end else if (hit_ier) begin
          if (dlab) begin
            dlm_d = wr_byte;
          end else begin
            ier_d = wr_byte;
          end
        end else if (hit_fcr) begin
          // FCR writes are accepted and dropped.
        end else if (hit_lcr) begin
          lcr_d = wr_byte;
        end else if (hit_scr) begin
          scr_d = wr_byte;
        end else begin
          result_o.bus_error = 1'b1;
        end
      end
      KindRx: begin
        if (!rx_valid_q) begin
          rx_valid_d        = 1'b1;
          rx_byte_d         = item_i.rx_byte;
          result_o.rx_taken = 1'b1;
        end
      end
      KindTick: begin
        time_d = time_q + DataW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q      <= '0;
      ier_q      <= '0;
      scr_q      <= '0;
      dll_q      <= '0;
      dlm_q      <= '0;
      rx_valid_q <= 1'b0;
      rx_byte_q  <= '0;
      time_q     <= '0;
    end else if (step_i) begin
      lcr_q      <= lcr_d;
      ier_q      <= ier_d;
      scr_q      <= scr_d;
      dll_q      <= dll_d;
      dlm_q      <= dlm_d;
      rx_valid_q <= rx_valid_d;
      rx_byte_q  <= rx_byte_d;
      time_q     <= time_d;
    end
  end

  `URM_ASSERT(a_rx_taken_fills, step_i && result_o.rx_taken |=> rx_valid_q)
  `URM_ASSERT(a_tick_counts, step_i && item_i.kind == KindTick |=> time_q == $past(time_q) + 64'd1)
  `URM_ASSERT_IF(a_tx_needs_no_dlab, step_i && result_o.tx_valid, !dlab && hit_rbr)

endmodule

`default_nettype wire

### rtl/uart_register_model.sv
// UART register model: a 16550-style register subset (RBR/THR, IER, FCR, LCR, LSR, SCR
// and the DLL/DLM divisor latches) plus a 64-bit mtime counter, driven by one transaction
// per item: a bus read, a bus write, an arriving receive byte or a time tick. Each
// transaction returns exactly one result. The block takes a new transaction in every
// cycle while in_stall_o is low; each passes an input register, a combinational address
// decode and register update, and a result register that holds it while the output side
// is stalled. While a waiting result is stalled, the input stalls in the same cycle once
// the input register holds a transaction. Configuration writes of the UART and timer
// base addresses are always accepted (cfg_ready_o is held high) and must only be issued
// while the block has no transaction in flight.

`default_nettype none

`include "uart_register_model_defines.svh"

module uart_register_model
  import urm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [AddrW-1:0]   address_i,
  input  wire logic [DataW-1:0]   write_value_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [DataW-1:0]        read_data_o,
  output logic                    bus_error_o,
  output logic                    tx_valid_o,
  output logic [ByteW-1:0]        tx_data_o,
  output logic                    rx_taken_o
);

  cfg_t    cfg;
  item_t   item_q, item_d;
  logic    in_valid_q;
  result_t result, result_q;
  logic    out_valid_q;
  logic    step;
  logic    in_accept;

  urm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  urm_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cfg_i   (cfg),
    .item_i  (item_q),
    .result_o(result)
  );

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.kind        = kind_e'(kind_i);
    item_d.address     = address_i;
    item_d.write_value = write_value_i;
    item_d.rx_byte     = rx_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign bus_error_o = result_q.bus_error;
  assign tx_valid_o  = result_q.tx_valid;
  assign tx_data_o   = result_q.tx_data;
  assign rx_taken_o  = result_q.rx_taken;

  `URM_ASSERT_IF(a_tx_excludes_err, out_valid_o && tx_valid_o, !bus_error_o && !rx_taken_o)
  `URM_ASSERT(a_drain_empties, out_valid_o && !out_stall_i && !in_valid_q |=> !out_valid_o)

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  import urm_pkg::*;

  localparam logic [AddrW-1:0] DirUart = 64'h0000_0000_1000_0000;
  localparam logic [AddrW-1:0] DirClint = 64'h0000_0000_0200_0000;
  localparam logic [AddrW-1:0] AllOnes = '1;
  localparam int unsigned Phases = 7;
  localparam int unsigned PhaseItems = 215;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AddrW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic [AddrW-1:0]   address_i;
  logic [DataW-1:0]   write_value_i;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [DataW-1:0]   read_data_o;
  logic               bus_error_o;
  logic               tx_valid_o;
  logic [ByteW-1:0]   tx_data_o;
  logic               rx_taken_o;

  // Tags that travel with the payload of the current transaction.
  bit      row_typed;
  result_t row_want;

  logic [AddrW-1:0] win_base = '0;
  logic [AddrW-1:0] timer_base = '0;
  logic [ByteW-1:0] lcr = '0;
  logic [ByteW-1:0] ier = '0;
  logic [ByteW-1:0] scr = '0;
  logic [ByteW-1:0] dll = '0;
  logic [ByteW-1:0] dlm = '0;
  bit               rbr_full = 1'b0;
  logic [ByteW-1:0] rbr_byte = '0;
  logic [DataW-1:0] mtime = '0;

  result_t response_q[$];
  row_t    directed_rows[$];
  int      mismatches = 0;
  bit      gaps_on = 1'b1;
  bit      quiet = 1'b0;
  bit      hold_off_req = 1'b0;

  uart_register_model dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .write_value_i (write_value_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .bus_error_o   (bus_error_o),
    .tx_valid_o    (tx_valid_o),
    .tx_data_o     (tx_data_o),
    .rx_taken_o    (rx_taken_o)
  );

  function automatic result_t mk_result(logic [DataW-1:0] rd, logic err, logic txv,
                                        logic [ByteW-1:0] txd, logic taken);
    result_t r;
    r.read_data = rd;
    r.bus_error = err;
    r.tx_valid = txv;
    r.tx_data = txd;
    r.rx_taken = taken;
    return r;
  endfunction

  // Applies one transaction to the register image and returns its response.
  function automatic result_t uart_respond(item_t it);
    result_t          r;
    logic [ByteW-1:0] b;
    r = '0;
    b = it.write_value[ByteW-1:0];
    case (it.kind)
      KindRead: begin
        if (it.address == win_base + UartLcrOff) r.read_data = DataW'(lcr);
        else if (it.address == win_base + UartIerOff) r.read_data = DataW'(ier);
        else if (it.address == win_base + UartLsrOff) begin
          r.read_data = DataW'(LsrThre | (rbr_full ? LsrDr : 8'h00));
        end else if (it.address == win_base + UartScrOff) r.read_data = DataW'(scr);
        else if (it.address == timer_base + MtimeOff) r.read_data = mtime;
        else if (it.address == win_base + UartRbrOff) begin
          if (rbr_full) begin
            r.read_data = DataW'(rbr_byte);
            rbr_full = 1'b0;
          end
        end else r.bus_error = 1'b1;
      end
      KindWrite: begin
        if (it.address == win_base + UartRbrOff) begin
          if (lcr[DlabBit]) dll = b;
          else begin
            r.tx_valid = 1'b1;
            r.tx_data = b;
          end
        end else if (it.address == win_base + UartIerOff) begin
          if (lcr[DlabBit]) dlm = b;
          else ier = b;
        end else if (it.address == win_base + UartFcrOff) begin
        end else if (it.address == win_base + UartLcrOff) lcr = b;
        else if (it.address == win_base + UartScrOff) scr = b;
        else r.bus_error = 1'b1;
      end
      KindRx: begin
        if (!rbr_full) begin
          rbr_byte = it.rx_byte;
          rbr_full = 1'b1;
          r.rx_taken = 1'b1;
        end
      end
      default: mtime = mtime + 1'b1;
    endcase
    return r;
  endfunction

  // Mostly accesses inside the register window, some at mtime, a few anywhere.
  function automatic item_t rand_item();
    item_t       it;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) it.kind = KindRead;
    else if (sel < 8) it.kind = KindWrite;
    else if (sel == 8) it.kind = KindRx;
    else it.kind = KindTick;
    sel = $urandom_range(0, 99);
    if (sel < 80) it.address = win_base + AddrW'($urandom_range(0, 7));
    else if (sel < 90) it.address = timer_base + MtimeOff;
    else it.address = {$urandom, $urandom};
    it.write_value = {$urandom, $urandom};
    it.rx_byte = ByteW'($urandom);
    return it;
  endfunction

  task automatic add_row(kind_e k, logic [AddrW-1:0] a, logic [DataW-1:0] wv,
                         logic [ByteW-1:0] rxb, bit typed, result_t want);
    row_t row;
    row.it.kind = k;
    row.it.address = a;
    row.it.write_value = wv;
    row.it.rx_byte = rxb;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic set_bases(logic [AddrW-1:0] ub, logic [AddrW-1:0] cb);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgUartBase;
    cfg_data_i <= ub;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_base = ub;
    cfg_index_i <= CfgClintBase;
    cfg_data_i <= cb;
    do @(posedge clk_i); while (!cfg_ready_o);
    timer_base = cb;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer(item_t it, bit typed, result_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    address_i <= it.address;
    write_value_i <= it.write_value;
    rx_byte_i <= it.rx_byte;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (response_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    item_t   acc;
    result_t pred;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        acc.kind = kind_e'(kind_i);
        acc.address = address_i;
        acc.write_value = write_value_i;
        acc.rx_byte = rx_byte_i;
        pred = uart_respond(acc);
        response_q.push_back(row_typed ? row_want : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (response_q.size() == 0) begin
          $error("response with no transaction pending");
          mismatches++;
        end else begin
          want = response_q.pop_front();
          check_field("read_data", want.read_data, read_data_o);
          check_field("bus_error", 64'(want.bus_error), 64'(bus_error_o));
          check_field("tx_valid", 64'(want.tx_valid), 64'(tx_valid_o));
          check_field("tx_data", 64'(want.tx_data), 64'(tx_data_o));
          check_field("rx_taken", 64'(want.rx_taken), 64'(rx_taken_o));
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    logic [AddrW-1:0] ub;
    logic [AddrW-1:0] cb;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgUartBase;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KindRead;
    address_i = '0;
    write_value_i = '0;
    rx_byte_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(KindRead, DirUart + UartLsrOff, '0, '0, 1, mk_result(DataW'(LsrThre), 0, 0, 0, 0));
    add_row(KindRead, DirUart + UartRbrOff, '0, '0, 1, mk_result('0, 0, 0, 0, 0));
    add_row(KindRead, DirUart + UartFcrOff, '0, '0, 1, mk_result('0, 1, 0, 0, 0));
    add_row(KindWrite, DirUart + UartLsrOff, '1, '0, 1, mk_result('0, 1, 0, 0, 0));
    add_row(KindWrite, DirClint + MtimeOff, '1, '0, 1, mk_result('0, 1, 0, 0, 0));
    add_row(KindRead, AllOnes, '0, '0, 1, mk_result('0, 1, 0, 0, 0));
    add_row(KindTick, AllOnes, '1, 8'hff, 1, mk_result('0, 0, 0, 0, 0));
    add_row(KindRead, DirClint + MtimeOff, '0, '0, 1, mk_result(64'd1, 0, 0, 0, 0));
    add_row(KindWrite, DirUart + UartRbrOff, '1, '0, 1, mk_result('0, 0, 1, 8'hff, 0));
    add_row(KindWrite, DirUart + UartRbrOff, '0, '0, 1, mk_result('0, 0, 1, 8'h00, 0));
    add_row(KindRx, AllOnes, '1, 8'ha5, 1, mk_result('0, 0, 0, 0, 1));
    add_row(KindRx, '0, '0, 8'h5a, 1, mk_result('0, 0, 0, 0, 0));
    add_row(KindRead, DirUart + UartLsrOff, '0, '0, 1,
            mk_result(DataW'(LsrThre | LsrDr), 0, 0, 0, 0));
    add_row(KindRead, DirUart + UartRbrOff, '0, '0, 1, mk_result(64'ha5, 0, 0, 0, 0));
    add_row(KindRead, DirUart + UartRbrOff, '0, '0, 1, mk_result('0, 0, 0, 0, 0));
    add_row(KindWrite, DirUart + UartIerOff, 64'h0f0f_0f0f_0f0f_00ff, '0, 0, '0);
    add_row(KindRead, DirUart + UartIerOff, '0, '0, 0, '0);
    add_row(KindWrite, DirUart + UartLcrOff, 64'h80, '0, 0, '0);
    add_row(KindWrite, DirUart + UartRbrOff, 64'h12, '0, 0, '0);
    add_row(KindWrite, DirUart + UartIerOff, 64'h34, '0, 0, '0);
    add_row(KindRead, DirUart + UartIerOff, '0, '0, 0, '0);
    add_row(KindRead, DirUart + UartLcrOff, '0, '0, 0, '0);
    add_row(KindWrite, DirUart + UartFcrOff, 64'hc7, '0, 0, '0);
    add_row(KindWrite, DirUart + UartScrOff, 64'hffff_ffff_ffff_ffab, '0, 0, '0);
    add_row(KindRead, DirUart + UartScrOff, '0, '0, 0, '0);
    add_row(KindWrite, DirUart + UartLcrOff, '0, '0, 0, '0);

    set_bases(DirUart, DirClint);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    for (int p = 0; p < Phases; p++) begin
      ub = {$urandom, $urandom};
      case (p)
        0: begin
          ub = '0;
          cb = AllOnes;
        end
        1: begin
          ub = AllOnes;
          cb = '0;
        end
        2: cb = ub + UartLsrOff - MtimeOff;
        3: cb = ub + UartRbrOff - MtimeOff;
        4: cb = ub + UartScrOff - MtimeOff;
        5: cb = ub + UartIerOff - MtimeOff;
        default: cb = {$urandom, $urandom};
      endcase
      set_bases(ub, cb);
      if (p == Phases - 1) begin
        gaps_on = 1'b0;
        quiet = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == 100) hold_off_req = 1'b1;
        if (p == 4 && n == 100) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (response_q.size() != 0);
        end
        offer(rand_item(), 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
